// ----- design/clb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package clb_pkg;

    // Default grid geometry
    localparam int CELLS_PER_AXIS_DEF = 16;
    localparam int CELL_CAPACITY_DEF  = 16;

    // Queue depths between the parts
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    // Fixed field widths
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int CELLS_W     = 5;
    localparam int INV_W       = 24;
    localparam int PIDX_W      = 12;
    localparam int POS_W       = 32;
    localparam int COORD_OUT_W = 4;
    localparam int SLOT_W      = 5;
    localparam int PROD_W      = POS_W + INV_W;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_Z   = 3'd5;

    // Register reset values
    localparam logic [CELLS_W-1:0] CELLS_RST = 5'd16;
    localparam logic [INV_W-1:0]   INV_RST   = 24'd65536;

    typedef enum logic {
        OP_CLEAR = 1'b0,
        OP_BIN   = 1'b1
    } t_op;

    typedef struct packed {
        logic [CELLS_W-1:0] cells_x;
        logic [CELLS_W-1:0] cells_y;
        logic [CELLS_W-1:0] cells_z;
        logic [INV_W-1:0]   inv_x;
        logic [INV_W-1:0]   inv_y;
        logic [INV_W-1:0]   inv_z;
    } t_cfg;

    // Classified item handed from front to back (cell id travels beside it)
    typedef struct packed {
        t_op                    op;
        logic [PIDX_W-1:0]      pidx;
        logic [COORD_OUT_W-1:0] cx;
        logic [COORD_OUT_W-1:0] cy;
        logic [COORD_OUT_W-1:0] cz;
    } t_bin_info;

    typedef struct packed {
        logic [COORD_OUT_W-1:0] cx;
        logic [COORD_OUT_W-1:0] cy;
        logic [COORD_OUT_W-1:0] cz;
        logic [SLOT_W-1:0]      slot;
        logic                   overflow;
    } t_result;

endpackage

`default_nettype wire

// ----- design/clb_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module clb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer and occupancy update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/clb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module clb_front #(
    parameter int CELLS_PER_AXIS = 16,
    parameter int IDW            = 12
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire clb_pkg::t_cfg                i_cfg,
    // item input
    input  wire logic                         i_push,
    output logic                              o_full,
    input  wire clb_pkg::t_op                 i_op,
    input  wire logic [clb_pkg::PIDX_W-1:0]   i_pidx,
    input  wire logic [clb_pkg::POS_W-1:0]    i_pos_x,
    input  wire logic [clb_pkg::POS_W-1:0]    i_pos_y,
    input  wire logic [clb_pkg::POS_W-1:0]    i_pos_z,
    // classified item toward the queue
    output logic                              o_push,
    input  wire logic                         i_q_full,
    output clb_pkg::t_bin_info                o_info,
    output logic [IDW-1:0]                    o_id
);

    import clb_pkg::*;

    localparam int CW = (CELLS_PER_AXIS > 1) ? $clog2(CELLS_PER_AXIS) : 1;

    // Effective cell count of an axis: zero acts as one, clamp at grid size
    function automatic logic [INV_W-1:0] eff_cells(input logic [CELLS_W-1:0] n);
        logic [INV_W-1:0] e;
        e = INV_W'(n);
        if (n == '0) begin
            e = INV_W'(1);
        end else if (INV_W'(n) > INV_W'(CELLS_PER_AXIS)) begin
            e = INV_W'(CELLS_PER_AXIS);
        end
        return e;
    endfunction

    // Saturate a raw coordinate to the last used cell
    function automatic logic [CW-1:0] sat_coord(input logic [INV_W-1:0] raw,
                                                 input logic [CELLS_W-1:0] n);
        logic [INV_W-1:0] e;
        logic [CW-1:0]    c;
        e = eff_cells(n);
        if (raw >= e) begin
            c = CW'(e - INV_W'(1));
        end else begin
            c = CW'(raw);
        end
        return c;
    endfunction

    logic                r_s1_valid;
    t_op                 r_s1_op;
    logic [PIDX_W-1:0]   r_s1_pidx;
    logic [INV_W-1:0]    r_s1_rx, r_s1_ry, r_s1_rz;
    logic [PROD_W-1:0]   prod_x, prod_y, prod_z;
    logic                load;
    logic [CW-1:0]       cx, cy, cz;

    assign o_full = r_s1_valid && i_q_full;
    assign load   = i_push && !o_full;
    assign o_push = r_s1_valid && !i_q_full;

    // Stage 1: scale each axis, keep integer part of the Q24.32 product
    assign prod_x = PROD_W'(i_pos_x) * PROD_W'(i_cfg.inv_x);
    assign prod_y = PROD_W'(i_pos_y) * PROD_W'(i_cfg.inv_y);
    assign prod_z = PROD_W'(i_pos_z) * PROD_W'(i_cfg.inv_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (load) begin
            r_s1_valid <= 1'b1;
        end else if (o_push) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s1_op   <= i_op;
            r_s1_pidx <= i_pidx;
            r_s1_rx   <= prod_x[PROD_W-1:POS_W];
            r_s1_ry   <= prod_y[PROD_W-1:POS_W];
            r_s1_rz   <= prod_z[PROD_W-1:POS_W];
        end
    end

    // Stage 2: saturate and form the linear cell id
    assign cx = sat_coord(r_s1_rx, i_cfg.cells_x);
    assign cy = sat_coord(r_s1_ry, i_cfg.cells_y);
    assign cz = sat_coord(r_s1_rz, i_cfg.cells_z);

    always_comb begin
        o_info.op   = r_s1_op;
        o_info.pidx = r_s1_pidx;
        o_info.cx   = COORD_OUT_W'(cx);
        o_info.cy   = COORD_OUT_W'(cy);
        o_info.cz   = COORD_OUT_W'(cz);
        o_id        = IDW'((IDW'(cx) * IDW'(CELLS_PER_AXIS) + IDW'(cy))
                           * IDW'(CELLS_PER_AXIS) + IDW'(cz));
    end

endmodule

`default_nettype wire

// ----- design/clb_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module clb_back #(
    parameter int CELLS_PER_AXIS = 16,
    parameter int CELL_CAPACITY  = 16,
    parameter int IDW            = 12
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // classified items from the queue
    input  wire logic                 i_q_empty,
    input  wire clb_pkg::t_bin_info   i_info,
    input  wire logic [IDW-1:0]       i_id,
    output logic                      o_q_pop,
    // results toward the output queue
    input  wire logic                 i_out_full,
    output logic                      o_out_push,
    output clb_pkg::t_result          o_result
);

    import clb_pkg::*;

    localparam int NC   = CELLS_PER_AXIS * CELLS_PER_AXIS * CELLS_PER_AXIS;
    localparam int CNTW = $clog2(CELL_CAPACITY + 1);
    localparam int NM   = NC * CELL_CAPACITY;
    localparam int MW   = (NM > 1) ? $clog2(NM) : 1;

    typedef enum logic [3:0] {
        S_INIT   = 4'b0001,
        S_IDLE   = 4'b0010,
        S_UPDATE = 4'b0100,
        S_CLEAR  = 4'b1000
    } t_back_state;

    logic [CNTW-1:0]   r_cnt_mem [NC];
    logic [PIDX_W-1:0] r_member_mem [NM];

    t_back_state       r_state, n_state;
    logic [IDW-1:0]    r_addr, n_addr;
    t_bin_info         r_item;
    logic [IDW-1:0]    r_id;
    logic [CNTW-1:0]   r_rd_cnt;

    logic              cnt_we;
    logic [IDW-1:0]    cnt_wa;
    logic [CNTW-1:0]   cnt_wd;
    logic              mem_we;
    logic [MW-1:0]     mem_wa;
    logic              cell_full;
    logic              sweep_last;

    assign sweep_last = (r_addr == IDW'(NC - 1));
    assign cell_full  = (r_rd_cnt >= CNTW'(CELL_CAPACITY));
    assign mem_wa     = MW'(r_id) * MW'(CELL_CAPACITY) + MW'(r_rd_cnt);

    // Sequencer: reset sweep, idle dispatch, count update, clear sweep
    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        o_q_pop    = 1'b0;
        o_out_push = 1'b0;
        o_result   = '0;
        cnt_we     = 1'b0;
        cnt_wa     = r_addr;
        cnt_wd     = '0;
        mem_we     = 1'b0;
        case (r_state)
            S_INIT: begin
                cnt_we = 1'b1;
                n_addr = r_addr + IDW'(1);
                if (sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_empty && !i_out_full) begin
                    o_q_pop = 1'b1;
                    n_addr  = '0;
                    n_state = (i_info.op == OP_CLEAR) ? S_CLEAR : S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_out_push  = 1'b1;
                o_result.cx = r_item.cx;
                o_result.cy = r_item.cy;
                o_result.cz = r_item.cz;
                cnt_wa      = r_id;
                if (cell_full) begin
                    o_result.overflow = 1'b1;
                end else begin
                    cnt_we        = 1'b1;
                    cnt_wd        = r_rd_cnt + CNTW'(1);
                    mem_we        = 1'b1;
                    o_result.slot = SLOT_W'(r_rd_cnt + CNTW'(1));
                end
                n_state = S_IDLE;
            end
            S_CLEAR: begin
                cnt_we = 1'b1;
                n_addr = r_addr + IDW'(1);
                if (sweep_last) begin
                    o_out_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
                n_addr  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    // Dispatched item
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_info;
            r_id   <= i_id;
        end
    end

    // Count memory: one write port, registered read at the queue head's cell
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_wa] <= cnt_wd;
        end
        r_rd_cnt <= r_cnt_mem[i_id];
    end

    // Member memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_member_mem[mem_wa] <= r_item.pidx;
        end
    end

endmodule

`default_nettype wire

// ----- design/cell_list_binning_top.sv -----
// Cell-list binning engine for a 3-D grid of CELLS_PER_AXIS^3 cells.
// Input channel (push/full): one transfer carries an operation, a particle
// index and an x/y/z position in unsigned Q16.16. Bin scales each axis by
// its reciprocal cell width, saturates to the last used cell, and appends
// the index to that cell; clear zeroes every cell count.
// Result channel (empty/pop): exactly one result per item, in order: cell
// coordinates, one-based slot, and an overflow flag for a full cell.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write a register.
// Path: a bin passes the front stage register, the middle queue, the back's
// dispatch and update states, then the result queue. The front (multiply,
// saturate) takes an item every cycle while the middle queue has room; the
// back does the count read-modify-write (registered read, then write back)
// for one bin before dispatching the next. A clear walks all CELLS_PER_AXIS^3
// count entries (4096 by default), one entry a cycle. Reset: the same walk
// clears the counts; items queue in front meanwhile and full rises once the
// queue fills. A stalled receiver fills the result queue, then the middle
// queue, then full is raised; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module cell_list_binning_top #(
    parameter int CELLS_PER_AXIS = clb_pkg::CELLS_PER_AXIS_DEF,
    parameter int CELL_CAPACITY  = clb_pkg::CELL_CAPACITY_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [clb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [clb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // item input
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic                             i_operation,
    input  wire logic [clb_pkg::PIDX_W-1:0]       i_particle_index,
    input  wire logic [clb_pkg::POS_W-1:0]        i_pos_x,
    input  wire logic [clb_pkg::POS_W-1:0]        i_pos_y,
    input  wire logic [clb_pkg::POS_W-1:0]        i_pos_z,
    // result output
    output logic                                  empty,
    input  wire logic                             pop,
    output logic [clb_pkg::COORD_OUT_W-1:0]       o_cell_x,
    output logic [clb_pkg::COORD_OUT_W-1:0]       o_cell_y,
    output logic [clb_pkg::COORD_OUT_W-1:0]       o_cell_z,
    output logic [clb_pkg::SLOT_W-1:0]            o_slot,
    output logic                                  o_overflow
);

    import clb_pkg::*;

    localparam int NC    = CELLS_PER_AXIS * CELLS_PER_AXIS * CELLS_PER_AXIS;
    localparam int IDW   = (NC > 1) ? $clog2(NC) : 1;
    localparam int INFW  = $bits(t_bin_info);
    localparam int MIDW  = IDW + INFW;
    localparam int RESW  = $bits(t_result);

    t_cfg              r_cfg;
    logic              mid_push, mid_full, mid_empty, mid_pop;
    t_bin_info         front_info, back_info;
    logic [IDW-1:0]    front_id, back_id;
    logic [MIDW-1:0]   mid_rd_data;
    logic              out_push, out_full;
    t_result           back_result, out_result;
    logic [RESW-1:0]   out_rd_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cells_x <= CELLS_RST;
            r_cfg.cells_y <= CELLS_RST;
            r_cfg.cells_z <= CELLS_RST;
            r_cfg.inv_x   <= INV_RST;
            r_cfg.inv_y   <= INV_RST;
            r_cfg.inv_z   <= INV_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CELLS_X: r_cfg.cells_x <= i_cfg_data[CELLS_W-1:0];
                CFG_CELLS_Y: r_cfg.cells_y <= i_cfg_data[CELLS_W-1:0];
                CFG_CELLS_Z: r_cfg.cells_z <= i_cfg_data[CELLS_W-1:0];
                CFG_INV_X:   r_cfg.inv_x   <= i_cfg_data[INV_W-1:0];
                CFG_INV_Y:   r_cfg.inv_y   <= i_cfg_data[INV_W-1:0];
                CFG_INV_Z:   r_cfg.inv_z   <= i_cfg_data[INV_W-1:0];
                default: ;
            endcase
        end
    end

    // Front: scale and classify
    clb_front #(
        .CELLS_PER_AXIS (CELLS_PER_AXIS),
        .IDW            (IDW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (push),
        .o_full   (full),
        .i_op     (t_op'(i_operation)),
        .i_pidx   (i_particle_index),
        .i_pos_x  (i_pos_x),
        .i_pos_y  (i_pos_y),
        .i_pos_z  (i_pos_z),
        .o_push   (mid_push),
        .i_q_full (mid_full),
        .o_info   (front_info),
        .o_id     (front_id)
    );

    // Queue between front and back
    clb_fifo #(
        .WIDTH (MIDW),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  ({front_id, front_info}),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_data  (mid_rd_data),
        .o_empty (mid_empty)
    );

    assign back_id   = mid_rd_data[MIDW-1:INFW];
    assign back_info = t_bin_info'(mid_rd_data[INFW-1:0]);

    // Back: count read-modify-write and clear walk
    clb_back #(
        .CELLS_PER_AXIS (CELLS_PER_AXIS),
        .CELL_CAPACITY  (CELL_CAPACITY),
        .IDW            (IDW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (mid_empty),
        .i_info     (back_info),
        .i_id       (back_id),
        .o_q_pop    (mid_pop),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_result   (back_result)
    );

    // Result queue
    clb_fifo #(
        .WIDTH (RESW),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (back_result),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_rd_data),
        .o_empty (empty)
    );

    assign out_result = t_result'(out_rd_data);
    assign o_cell_x   = out_result.cx;
    assign o_cell_y   = out_result.cy;
    assign o_cell_z   = out_result.cz;
    assign o_slot     = out_result.slot;
    assign o_overflow = out_result.overflow;

endmodule

`default_nettype wire
